@@ rtl/can_signal_extract_scale_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the CAN signal decoder
// Immediate-consequence and next-cycle property forms, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_EXTRACT_SCALE_ASSERT_SVH
`define CAN_SIGNAL_EXTRACT_SCALE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CSE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/cse_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN signal decoder package
// Field widths, register map and limits shared by the channels and the core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cse_pkg;

   localparam int ID_W      = 29;
   localparam int DATA_W    = 64;
   localparam int LEN_W     = 4;
   localparam int START_W   = 6;
   localparam int BLEN_W    = 7;
   localparam int FACTOR_W  = 32;
   localparam int OFFSET_W  = 48;

   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   // Scaling datapath: half-word split of the field, partial product and sum.
   localparam int HALF_W = DATA_W / 2;
   localparam int PP_W   = HALF_W + 1 + FACTOR_W;
   localparam int SUM_W  = PP_W + HALF_W + 1;

   // Register indexes; byte address is eight times the index.
   localparam logic [CSR_IDX_W-1:0] REG_MESSAGE_ID   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_START_BIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BIT_LENGTH   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_INTEL_ORDER  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SIGNED_FIELD = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_FACTOR = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE_OFFSET = 3'd6;

   localparam logic signed [DATA_W-1:0] PHYS_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [DATA_W-1:0] PHYS_MIN = 64'sh8000_0000_0000_0000;

endpackage

@@ rtl/cse_channels.sv @@
// ----------------------------------------------------------------------------
// CAN signal decoder channels
// Valid/ready interfaces for the frame input and the decoded signal output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cse_req_if;
   import cse_pkg::*;

   logic              valid;
   logic              ready;
   logic [ID_W-1:0]   frame_id;
   logic [DATA_W-1:0] payload;
   logic [LEN_W-1:0]  payload_len;

   modport source (output valid, frame_id, payload, payload_len, input ready);
   modport sink   (input valid, frame_id, payload, payload_len, output ready);
endinterface

interface cse_rsp_if;
   import cse_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     matched;
   logic [DATA_W-1:0]        raw_value;
   logic signed [DATA_W-1:0] physical_value;
   logic                     saturated;

   modport source (output valid, matched, raw_value, physical_value, saturated,
                   input ready);
   modport sink   (input valid, matched, raw_value, physical_value, saturated,
                   output ready);
endinterface

@@ rtl/can_signal_extract_scale.sv @@
// ----------------------------------------------------------------------------
// CAN signal extract and scale
// Decodes one configured signal from each CAN frame and scales it to Q48.16.
// ----------------------------------------------------------------------------
// A frame word is accepted on the request channel whenever the pipeline has
// room, one word per clock cycle when the result side keeps up, and its
// decoded signal reaches the response channel through five register stages:
// the input register, the field shifter, the field alignment and sign
// extension, the two 33 by 32 bit partial products of the scaling multiply,
// and the final 98-bit sum with saturation that feeds the output register.
// Each stage holds its word while the stage after it is full and stalled, so
// no word is lost when the response channel stalls, and empty stages still
// take new words. The signal description (identifier, start bit, length, byte
// order, signedness, factor and offset) lives in seven registers behind an
// APB-style port with 64-bit data at byte address eight times the register
// index; they should be written only while no frame is in flight.
`timescale 1ns / 1ps

`include "can_signal_extract_scale_assert.svh"

module can_signal_extract_scale (
   input  logic                             clock,
   input  logic                             reset,
   cse_req_if.sink                          req_if,
   cse_rsp_if.source                        rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [cse_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [cse_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [cse_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                             csr_pready
);
   import cse_pkg::*;

   // -------------------------------------------------------------------------
   // Configuration registers
   // -------------------------------------------------------------------------
   logic [ID_W-1:0]            message_id_ff;
   logic [START_W-1:0]         start_bit_ff;
   logic [BLEN_W-1:0]          bit_length_ff;
   logic                       intel_order_ff;
   logic                       signed_field_ff;
   logic signed [FACTOR_W-1:0] scale_factor_ff;
   logic signed [OFFSET_W-1:0] scale_offset_ff;

   logic                       csr_write;
   logic [CSR_IDX_W-1:0]       csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-CSR_IDX_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         message_id_ff   <= '0;
         start_bit_ff    <= '0;
         bit_length_ff   <= BLEN_W'(8);
         intel_order_ff  <= 1'b1;
         signed_field_ff <= 1'b0;
         scale_factor_ff <= FACTOR_W'(65536);
         scale_offset_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MESSAGE_ID:   message_id_ff   <= csr_pwdata[ID_W-1:0];
            REG_START_BIT:    start_bit_ff    <= csr_pwdata[START_W-1:0];
            REG_BIT_LENGTH:   bit_length_ff   <= csr_pwdata[BLEN_W-1:0];
            REG_INTEL_ORDER:  intel_order_ff  <= csr_pwdata[0];
            REG_SIGNED_FIELD: signed_field_ff <= csr_pwdata[0];
            REG_SCALE_FACTOR: scale_factor_ff <= csr_pwdata[FACTOR_W-1:0];
            REG_SCALE_OFFSET: scale_offset_ff <= csr_pwdata[OFFSET_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Read data: each register is returned zero-extended to the data width.
   always_comb begin
      case (csr_index)
         REG_MESSAGE_ID:   csr_prdata = CSR_DATA_W'(message_id_ff);
         REG_START_BIT:    csr_prdata = CSR_DATA_W'(start_bit_ff);
         REG_BIT_LENGTH:   csr_prdata = CSR_DATA_W'(bit_length_ff);
         REG_INTEL_ORDER:  csr_prdata = CSR_DATA_W'(intel_order_ff);
         REG_SIGNED_FIELD: csr_prdata = CSR_DATA_W'(signed_field_ff);
         REG_SCALE_FACTOR: csr_prdata = CSR_DATA_W'($unsigned(scale_factor_ff));
         REG_SCALE_OFFSET: csr_prdata = CSR_DATA_W'($unsigned(scale_offset_ff));
         default:          csr_prdata = '0;
      endcase
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control. A stage loads when it is empty or when its word
   // moves on in the same cycle; the chain ends at the response handshake.
   // -------------------------------------------------------------------------
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_if.ready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign rdy0 = !v0_ff || rdy1;

   assign req_if.ready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy0) v0_ff <= req_if.valid;
         if (rdy1) v1_ff <= v0_ff;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 0: input register.
   // -------------------------------------------------------------------------
   logic [ID_W-1:0]   s0_frame_id_ff;
   logic [DATA_W-1:0] s0_payload_ff;
   logic [LEN_W-1:0]  s0_len_ff;

   always_ff @(posedge clock) begin
      if (rdy0) begin
         s0_frame_id_ff <= req_if.frame_id;
         s0_payload_ff  <= req_if.payload;
         s0_len_ff      <= req_if.payload_len;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 1: blank bytes beyond the frame length and shift the field start
   // down to bit 0. For Motorola order the bits of each byte are reversed
   // first, which turns the MSB-first walk (down within a byte, then to bit 7
   // of the next byte) into a plain upward walk from the start position.
   // Bits shifted in from beyond byte 7 are zero.
   // -------------------------------------------------------------------------
   logic [DATA_W-1:0]  s1_masked;
   logic [DATA_W-1:0]  s1_byte_rev;
   logic [START_W-1:0] s1_moto_start;
   logic [DATA_W-1:0]  s1_shift_in;
   logic [DATA_W-1:0]  s1_shift_ff;
   logic               s1_matched_ff;

   always_comb begin
      for (int b = 0; b < DATA_W / 8; b++) begin
         // A length register above eight compares the same as eight here.
         if (LEN_W'(b) < s0_len_ff) begin
            s1_masked[8*b +: 8] = s0_payload_ff[8*b +: 8];
         end else begin
            s1_masked[8*b +: 8] = 8'h00;
         end
         for (int k = 0; k < 8; k++) begin
            s1_byte_rev[8*b + 7 - k] = s1_masked[8*b + k];
         end
      end
      s1_moto_start = {start_bit_ff[START_W-1:3], ~start_bit_ff[2:0]};
      if (intel_order_ff) begin
         s1_shift_in = s1_masked >> start_bit_ff;
      end else begin
         s1_shift_in = s1_byte_rev >> s1_moto_start;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_shift_ff   <= s1_shift_in;
         s1_matched_ff <= (s0_frame_id_ff == message_id_ff);
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: bring the field to the top of the word (Intel by a left shift,
   // Motorola by a full bit reversal, which also puts the first bit walked at
   // the top), then shift it back down, arithmetically when signed. An
   // invalid length of zero or above 64 gives a zero field.
   // -------------------------------------------------------------------------
   logic              s2_len_ok;
   logic [BLEN_W-1:0] s2_pad;
   logic [DATA_W-1:0] s2_top;
   logic [DATA_W-1:0] s2_raw_in;
   logic              s2_neg_in;
   logic [DATA_W-1:0] s2_raw_ff;
   logic              s2_neg_ff;
   logic              s2_matched_ff;

   always_comb begin
      s2_len_ok = (bit_length_ff != '0) && (bit_length_ff <= BLEN_W'(DATA_W));
      s2_pad    = BLEN_W'(DATA_W) - bit_length_ff;
      if (intel_order_ff) begin
         s2_top = s1_shift_ff << s2_pad;
      end else begin
         for (int i = 0; i < DATA_W; i++) begin
            s2_top[DATA_W - 1 - i] = s1_shift_ff[i];
         end
      end
      if (!s2_len_ok) begin
         s2_raw_in = '0;
      end else if (signed_field_ff) begin
         s2_raw_in = $unsigned($signed(s2_top) >>> s2_pad);
      end else begin
         s2_raw_in = s2_top >> s2_pad;
      end
      s2_neg_in = s2_len_ok && signed_field_ff && s2_top[DATA_W-1];
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_raw_ff     <= s2_raw_in;
         s2_neg_ff     <= s2_neg_in;
         s2_matched_ff <= s1_matched_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: the 65-bit signed field times the 32-bit signed factor, split
   // into a low half (unsigned 32 bits) and a high half (signed 33 bits).
   // -------------------------------------------------------------------------
   logic signed [HALF_W:0]   s3_lo_op;
   logic signed [HALF_W:0]   s3_hi_op;
   logic signed [PP_W-1:0]   s3_pp_lo_ff;
   logic signed [PP_W-1:0]   s3_pp_hi_ff;
   logic [DATA_W-1:0]        s3_raw_ff;
   logic                     s3_matched_ff;

   assign s3_lo_op = {1'b0, s2_raw_ff[HALF_W-1:0]};
   assign s3_hi_op = {s2_neg_ff, s2_raw_ff[DATA_W-1:HALF_W]};

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_pp_lo_ff   <= s3_lo_op * scale_factor_ff;
         s3_pp_hi_ff   <= s3_hi_op * scale_factor_ff;
         s3_raw_ff     <= s2_raw_ff;
         s3_matched_ff <= s2_matched_ff;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: recombine the partial products, add the offset and clip the
   // exact sum to the signed 64-bit range.
   // -------------------------------------------------------------------------
   logic signed [SUM_W-1:0]  s4_hi_ext;
   logic signed [SUM_W-1:0]  s4_lo_ext;
   logic signed [SUM_W-1:0]  s4_off_ext;
   logic signed [SUM_W-1:0]  s4_sum;
   logic                     s4_fits;
   logic signed [DATA_W-1:0] s4_phys_in;
   logic                     s4_sat_in;

   logic                     s4_matched_ff;
   logic [DATA_W-1:0]        s4_raw_ff;
   logic signed [DATA_W-1:0] s4_phys_ff;
   logic                     s4_sat_ff;

   always_comb begin
      s4_hi_ext  = {s3_pp_hi_ff[PP_W-1], s3_pp_hi_ff, {HALF_W{1'b0}}};
      s4_lo_ext  = {{(SUM_W-PP_W){s3_pp_lo_ff[PP_W-1]}}, s3_pp_lo_ff};
      s4_off_ext = {{(SUM_W-OFFSET_W){scale_offset_ff[OFFSET_W-1]}}, scale_offset_ff};
      s4_sum     = s4_hi_ext + s4_lo_ext + s4_off_ext;
      s4_fits    = (s4_sum[SUM_W-1:DATA_W-1] == '0)
                   || (s4_sum[SUM_W-1:DATA_W-1] == '1);
      if (s4_fits) begin
         s4_phys_in = s4_sum[DATA_W-1:0];
         s4_sat_in  = 1'b0;
      end else begin
         s4_phys_in = s4_sum[SUM_W-1] ? PHYS_MIN : PHYS_MAX;
         s4_sat_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_matched_ff <= s3_matched_ff;
         s4_raw_ff     <= s3_raw_ff;
         s4_phys_ff    <= s4_phys_in;
         s4_sat_ff     <= s4_sat_in;
      end
   end

   assign rsp_if.valid          = v4_ff;
   assign rsp_if.matched        = s4_matched_ff;
   assign rsp_if.raw_value      = s4_raw_ff;
   assign rsp_if.physical_value = s4_phys_ff;
   assign rsp_if.saturated      = s4_sat_ff;

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   `CSE_ASSERT_NEXT(a_accept_loads, clock, reset, req_if.valid && req_if.ready,
      v0_ff, "accepted frame word did not reach the input register")
   `CSE_ASSERT_NEXT(a_stall_holds, clock, reset, v2_ff && !rdy3,
      v2_ff && $stable(s2_raw_ff), "stalled field stage lost or changed its word")
   `CSE_ASSERT_NEXT(a_last_moves, clock, reset, v3_ff && rdy4,
      v4_ff, "product stage word did not reach the output register")
   `CSE_ASSERT_NOW(a_sat_value, clock, reset, v4_ff && s4_sat_ff,
      s4_phys_ff == PHYS_MAX || s4_phys_ff == PHYS_MIN,
      "saturated result is not a range limit")

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// CAN signal decoder testbench
// Drives frame words through the decoder under a series of signal settings,
// predicts every decoded word in the bench and checks the response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import cse_pkg::*;

   // Frame word as offered on the request channel.
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] payload;
      logic [LEN_W-1:0]  len;
   } frame_type;

   // Decoded signal word as it should appear on the response channel.
   typedef struct packed {
      logic              matched;
      logic [DATA_W-1:0] raw;
      logic [DATA_W-1:0] phys;
      logic              sat;
   } decoded_type;

   localparam int N_FRAMES    = 1450;
   localparam int CALM_FROM   = 1250;   // no idling on either side past this count
   localparam int HOLD_CYCLES = 150;    // long receiver hold-off
   localparam int QUIET_LIMIT = 2000;   // cycles without any traffic before giving up
   localparam int SETTLE_WAIT = 20;     // pipeline is five stages deep
   localparam int MAX_REPORTS = 10;

   logic clock = 1'b0;
   logic reset;

   cse_req_if req_ch ();
   cse_rsp_if rsp_ch ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   can_signal_extract_scale i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_ch),
      .rsp_if      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Bench copy of the signal description. The values start at the reset
   // state of the block, so the first frames check the reset values too.
   // -------------------------------------------------------------------------
   logic [ID_W-1:0]            cfg_id     = '0;
   logic [START_W-1:0]         cfg_start  = '0;
   logic [BLEN_W-1:0]          cfg_blen   = 7'd8;
   logic                       cfg_intel  = 1'b1;
   logic                       cfg_signed = 1'b0;
   logic signed [FACTOR_W-1:0] cfg_factor = 32'sd65536;
   logic signed [OFFSET_W-1:0] cfg_offset = '0;

   // Shared bookkeeping between the stimulus, the driver and the checker.
   frame_type   frames_to_send[$];
   decoded_type decodes_due[$];
   int       n_sent      = 0;    // frames queued for the driver
   int       n_done      = 0;    // decoded words checked against a prediction
   int       n_mismatch  = 0;
   int       hold_asked  = 0;    // raised by the stimulus to ask for a hold-off
   int       hold_done   = 0;
   logic     idling_on   = 1'b0;

   // -------------------------------------------------------------------------
   // Predictor. The field is collected bit by bit exactly as the block's
   // definition walks it: in Intel order upwards from the start bit, in
   // Motorola order downwards from the start bit, jumping from bit 0 of a
   // byte to bit 7 of the next one. Positions past bit 63 or in bytes at or
   // beyond the frame length read as zero. The scaling is done at 128 bits,
   // wide enough that the exact sum can be tested against the 64-bit range.
   // -------------------------------------------------------------------------
   function automatic decoded_type decode_frame(frame_type fr);
      int unsigned         nbytes;
      int unsigned         pos;
      int unsigned         k;
      logic [DATA_W-1:0]   field;
      logic                len_ok;
      logic signed [127:0] raw_w;
      logic signed [127:0] fac_w;
      logic signed [127:0] off_w;
      logic signed [127:0] sum_w;
      decoded_type         d;

      nbytes = (fr.len > 4'd8) ? 8 : fr.len;   // lengths nine to fifteen act as eight
      len_ok = (cfg_blen >= 7'd1) && (cfg_blen <= 7'd64);
      field  = '0;
      if (len_ok) begin
         pos = cfg_start;
         for (k = 0; k < cfg_blen; k++) begin
            if (cfg_intel)
               pos = cfg_start + k;
            if (pos < 64 && (pos >> 3) < nbytes)
               field[cfg_intel ? k : cfg_blen - 1 - k] = fr.payload[pos];
            if (!cfg_intel)
               pos = (pos % 8 == 0) ? pos + 15 : pos - 1;
         end
         if (cfg_signed && cfg_blen < 7'd64 && field[cfg_blen - 1])
            field = field | ~((64'd1 << cfg_blen) - 64'd1);
      end

      // A full-width field stays unsigned unless sign extension is asked for.
      if (cfg_signed && len_ok)
         raw_w = $signed(field);
      else
         raw_w = $signed({64'd0, field});
      fac_w = cfg_factor;
      off_w = cfg_offset;
      sum_w = raw_w * fac_w + off_w;

      d.matched = (fr.id == cfg_id);
      d.raw     = field;
      if (sum_w > PHYS_MAX) begin
         d.phys = PHYS_MAX;
         d.sat  = 1'b1;
      end else if (sum_w < PHYS_MIN) begin
         d.phys = PHYS_MIN;
         d.sat  = 1'b1;
      end else begin
         d.phys = sum_w[DATA_W-1:0];
         d.sat  = 1'b0;
      end
      return d;
   endfunction

   // -------------------------------------------------------------------------
   // Request driver. A new word is only put on the channel once the previous
   // one has gone, and each path below assigns valid exactly once per edge.
   // While idling is enabled the driver drops valid for random bursts.
   // -------------------------------------------------------------------------
   int src_gap = 0;

   always @(posedge clock) begin : request_driver
      frame_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (src_gap > 0) begin
            src_gap = src_gap - 1;
            req_ch.valid <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            src_gap = $urandom_range(0, 16);
            req_ch.valid <= 1'b0;
         end else if (frames_to_send.size() > 0) begin
            nxt = frames_to_send.pop_front();
            req_ch.valid       <= 1'b1;
            req_ch.frame_id    <= nxt.id;
            req_ch.payload     <= nxt.payload;
            req_ch.payload_len <= nxt.len;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Response ready. Besides the random stall bursts, the stimulus can ask
   // for one long hold-off; the frames keep coming meanwhile, so the pipeline
   // fills and the block has to stall its request side.
   // -------------------------------------------------------------------------
   int snk_gap   = 0;
   int hold_left = 0;

   always @(posedge clock) begin : response_ready
      logic rdy;
      rdy = 1'b1;
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rdy = 1'b0;
      end else if (hold_asked != hold_done) begin
         hold_done = hold_done + 1;
         hold_left = HOLD_CYCLES - 1;
         rdy = 1'b0;
      end else if (snk_gap > 0) begin
         snk_gap = snk_gap - 1;
         rdy = 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         snk_gap = $urandom_range(0, 16);
         rdy = 1'b0;
      end
      rsp_ch.ready <= reset ? 1'b0 : rdy;
   end

   // -------------------------------------------------------------------------
   // Monitor and checker. Every accepted frame word gets its prediction
   // queued; every accepted response word is compared field by field with
   // the oldest prediction.
   // -------------------------------------------------------------------------
   task automatic flag_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      n_mismatch++;
      if (n_mismatch <= MAX_REPORTS)
         $display("%0t: %s wrong: expected %h, got %h", $realtime, what, want, got);
   endtask

   always @(posedge clock) begin : monitor
      frame_type   fr;
      decoded_type got;
      decoded_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            fr = '{req_ch.frame_id, req_ch.payload, req_ch.payload_len};
            decodes_due.insert(decodes_due.size(), decode_frame(fr));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.matched, rsp_ch.raw_value, rsp_ch.physical_value,
                    rsp_ch.saturated};
            if (decodes_due.size() == 0) begin
               flag_mismatch("unexpected word, raw_value", '0, got.raw);
            end else begin
               want = decodes_due.pop_front();
               if (got.matched !== want.matched)
                  flag_mismatch("matched", want.matched, got.matched);
               if (got.raw !== want.raw)
                  flag_mismatch("raw_value", want.raw, got.raw);
               if (got.phys !== want.phys)
                  flag_mismatch("physical_value", want.phys, got.phys);
               if (got.sat !== want.sat)
                  flag_mismatch("saturated", want.sat, got.sat);
               n_done++;
            end
         end
      end
   end

   // The watchdog only counts cycles in which nothing at all moves.
   int quiet = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_psel) begin
         quiet = 0;
      end else begin
         quiet = quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no traffic for %0d cycles, %0d words outstanding",
                     $realtime, QUIET_LIMIT, n_sent - n_done);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Register access. A write is a setup cycle followed by an access cycle;
   // the register takes the value at the edge that ends the access cycle,
   // after which the bench copy is updated with the same masking.
   // -------------------------------------------------------------------------
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MESSAGE_ID:   cfg_id     = value[ID_W-1:0];
         REG_START_BIT:    cfg_start  = value[START_W-1:0];
         REG_BIT_LENGTH:   cfg_blen   = value[BLEN_W-1:0];
         REG_INTEL_ORDER:  cfg_intel  = value[0];
         REG_SIGNED_FIELD: cfg_signed = value[0];
         REG_SCALE_FACTOR: cfg_factor = value[FACTOR_W-1:0];
         REG_SCALE_OFFSET: cfg_offset = value[OFFSET_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [63:0] id, input logic [63:0] start,
                                input logic [63:0] blen, input logic [63:0] intel,
                                input logic [63:0] signd, input logic [63:0] factor,
                                input logic [63:0] offset);
      csr_write(REG_MESSAGE_ID, id);
      csr_write(REG_START_BIT, start);
      csr_write(REG_BIT_LENGTH, blen);
      csr_write(REG_INTEL_ORDER, intel);
      csr_write(REG_SIGNED_FIELD, signd);
      csr_write(REG_SCALE_FACTOR, factor);
      csr_write(REG_SCALE_OFFSET, offset);
   endtask

   // Random setting, leaning on the extremes. Bits above each register's
   // width are left random; the block is expected to drop them.
   task automatic random_setting();
      logic [63:0] start_w;
      logic [63:0] blen_w;
      logic [63:0] fac_w;
      logic [63:0] off_w;
      start_w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: start_w[5:0] = 6'd0;
         1: start_w[5:0] = 6'd63;
         default: ;
      endcase
      blen_w = {$urandom, $urandom};
      case ($urandom_range(0, 15))
         0:       blen_w[6:0] = 7'd0;
         1:       blen_w[6:0] = 7'($urandom_range(65, 127));
         2:       blen_w[6:0] = 7'd1;
         3, 4:    blen_w[6:0] = 7'd64;
         default: blen_w[6:0] = 7'($urandom_range(1, 64));
      endcase
      fac_w = {$urandom, $urandom};
      case ($urandom_range(0, 7))
         0: fac_w[31:0] = 32'h8000_0000;
         1: fac_w[31:0] = 32'h7FFF_FFFF;
         2: fac_w[31:0] = 32'h0000_0000;
         3: fac_w[31:0] = 32'h0001_0000;
         4: fac_w[31:0] = 32'hFFFF_0000;
         5: fac_w[31:0] = $urandom_range(0, 32'h000F_FFFF) ^ {32{$urandom_range(0, 1) == 1}};
         default: ;
      endcase
      off_w = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: off_w[47:0] = 48'h8000_0000_0000;
         1: off_w[47:0] = 48'h7FFF_FFFF_FFFF;
         2: off_w[47:0] = 48'h0;
         default: ;
      endcase
      apply_setting({$urandom, $urandom}, start_w, blen_w, {$urandom, $urandom},
                    {$urandom, $urandom}, fac_w, off_w);
   endtask

   task automatic queue_frame(input logic [ID_W-1:0] id, input logic [DATA_W-1:0] payload,
                              input logic [LEN_W-1:0] len);
      frame_type fr;
      fr = '{id, payload, len};
      frames_to_send.insert(frames_to_send.size(), fr);
      n_sent++;
   endtask

   // Frame with random content; about half carry the configured identifier
   // and some differ from it in a single bit.
   task automatic queue_random_frame();
      logic [ID_W-1:0]   id;
      logic [DATA_W-1:0] payload;
      logic [LEN_W-1:0]  len;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: id = cfg_id;
         5:             id = cfg_id ^ (29'd1 << $urandom_range(0, ID_W - 1));
         default:       id = ID_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0:       payload = '1;
         1:       payload = '0;
         2:       payload = 64'd1 << $urandom_range(0, 63);
         default: payload = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 19))
         0, 1, 2, 3, 4:    len = LEN_W'($urandom_range(0, 7));
         5, 6, 7:          len = LEN_W'($urandom_range(9, 15));
         default:          len = 4'd8;
      endcase
      queue_frame(id, payload, len);
   endtask

   // Waits until every queued frame has come back decoded. Sampling on the
   // falling edge keeps clear of the updates made at the rising edge.
   task automatic wait_drained();
      do @(negedge clock); while (n_done != n_sent);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus: a directed part at the reset setting and at a handful of
   // corner settings, then random settings each followed by a batch of
   // random frames. The registers are only touched once the block is empty.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int phase;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.frame_id    = '0;
      req_ch.payload     = '0;
      req_ch.payload_len = '0;
      rsp_ch.ready       = 1'b0;
      csr_psel           = 1'b0;
      csr_penable        = 1'b0;
      csr_pwrite         = 1'b0;
      csr_paddr          = '0;
      csr_pwdata         = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (reset);

      // Reset setting: identifier zero, byte 0 as unsigned, unity factor.
      queue_frame('0, '1, 4'd8);
      queue_frame('1, 64'h0123_4567_89AB_CDEF, 4'd8);
      queue_frame('0, '1, 4'd0);
      queue_frame(29'd1, '1, 4'd15);
      queue_frame('0, 64'hA5, 4'd1);
      queue_frame('0, '0, 4'd8);
      wait_drained();

      // Motorola full width, unsigned with bit 63 set, largest factor and
      // offset: the sum overflows upwards.
      apply_setting(64'h1FFF_FFFF, 64'd7, 64'd64, 64'd0, 64'd0,
                    64'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF);
      queue_frame('1, '1, 4'd8);
      queue_frame('0, 64'h80, 4'd1);
      queue_frame('1, '0, 4'd8);
      wait_drained();

      // Signed full width, most negative factor and offset: overflow both ways.
      apply_setting(64'd0, 64'd0, 64'd64, 64'd1, 64'd1,
                    64'h8000_0000, 64'h8000_0000_0000);
      queue_frame('0, '1, 4'd8);
      queue_frame('0, 64'h8000_0000_0000_0000, 4'd8);
      queue_frame('0, 64'h7FFF_FFFF_FFFF_FFFF, 4'd8);
      wait_drained();

      // Zero length: the decode gives only the offset.
      apply_setting(64'd5, 64'd3, 64'd0, 64'd1, 64'd1, 64'h0001_0000,
                    64'hFFFF_FFFB_0000);
      queue_frame(29'd5, '1, 4'd8);
      queue_frame(29'd4, 64'h1234, 4'd2);
      wait_drained();

      // Length beyond 64 behaves the same way.
      csr_write(REG_BIT_LENGTH, 64'd127);
      queue_frame(29'd5, '1, 4'd8);
      queue_frame(29'd5, '0, 4'd0);
      wait_drained();

      // Intel field starting at bit 63: all but one bit lies past the payload.
      apply_setting(64'd9, 64'd63, 64'd64, 64'd1, 64'd1, 64'h0000_8000, 64'd0);
      queue_frame(29'd9, 64'h8000_0000_0000_0000, 4'd8);
      queue_frame(29'd9, '1, 4'd7);
      wait_drained();

      // Motorola from bit 0 of a byte, so the walk jumps into the next byte.
      apply_setting(64'd2, 64'd0, 64'd16, 64'd0, 64'd1, 64'hFFFF_0000, 64'h123);
      queue_frame(29'd2, 64'h0000_0000_0000_8001, 4'd8);
      queue_frame(29'd2, 64'h0000_0000_0000_7F01, 4'd2);
      wait_drained();

      // Random part. The third batch brings the long receiver hold-off,
      // with the sender offering frames throughout.
      phase = 0;
      while (n_sent < N_FRAMES) begin
         random_setting();
         if (n_sent >= CALM_FROM)
            idling_on = 1'b0;
         else
            idling_on = ($urandom_range(0, 3) != 0);
         if (phase == 2) begin
            idling_on  = 1'b0;
            hold_asked = hold_asked + 1;
         end
         repeat ($urandom_range(30, 90)) queue_random_frame();
         wait_drained();
         phase++;
      end

      idling_on = 1'b0;
      repeat (SETTLE_WAIT) @(negedge clock);
      if (decodes_due.size() != 0)
         $display("%0d decoded words never arrived", decodes_due.size());
      if (n_mismatch == 0 && decodes_due.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cse_pkg.sv
rtl/cse_channels.sv
rtl/can_signal_extract_scale.sv
dv/tb_top.sv
